FILE: rtl/hdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdr_pkg
// Shared types and constants for the histogram duplicate reporter.
// ----------------------------------------------------------------------------
package hdr_pkg;

  // Fixed field widths
  localparam int unsigned VAL_W = 5;
  localparam int unsigned OCC_W = 7;

  // Input transfer payload
  typedef struct packed {
    logic [VAL_W-1:0] item_value;
    logic             last_item;
  } hdr_in_t;

  // Result transfer payload
  typedef struct packed {
    logic [VAL_W-1:0] dup_value;
    logic [OCC_W-1:0] occurrences;
    logic             total_flag;
    logic             last_result;
  } hdr_out_t;

  // Report sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_TOTAL = 2'd2
  } hdr_state_e;

  // Status from the report sequencer to the loader
  typedef struct packed {
    logic busy;
    logic clear;
  } hdr_sts_t;

endpackage

FILE: rtl/hdr_bin_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdr_bin_mem
// Bin count memory: one write port, one registered read port, per-entry
// valid bits so that unwritten or cleared entries read as zero.
// ----------------------------------------------------------------------------
module hdr_bin_mem #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5,
  parameter int unsigned DW    = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          clr_i
);

  logic [DW-1:0]    mem_q [DEPTH];
  logic [DW-1:0]    rd_q;
  logic [DEPTH-1:0] valid_q;
  logic             rd_vld_q;

  // Storage array, synchronous read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bits: cleared at reset and at the end of each report
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

FILE: rtl/hdr_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdr_scan
// Report sequencer: walks the bins from zero up to the largest value, emits
// one result per duplicated value, then the total, then clears the state.
// ----------------------------------------------------------------------------
module hdr_scan
  import hdr_pkg::*;
#(
  parameter int unsigned BIN_W = 5,
  parameter int unsigned CNT_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [BIN_W-1:0] largest_i,
  output logic             rd_en_o,
  output logic [BIN_W-1:0] rd_addr_o,
  input  logic [CNT_W-1:0] rd_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output hdr_out_t         out_data_o,
  output hdr_sts_t         sts_o
);

  hdr_state_e       state_q, state_d;
  logic [BIN_W-1:0] idx_q;
  logic             iss_done_q;
  logic             p_valid_q;
  logic [BIN_W-1:0] p_idx_q;
  logic [OCC_W-1:0] dups_q;
  logic             out_valid_q;
  hdr_out_t         out_q;

  logic cand;
  logic out_free;
  logic advance;
  logic load_dup;
  logic load_tot;
  logic clear;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!p_valid_q && iss_done_q) state_d = ST_TOTAL;
      end
      ST_TOTAL: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    cand     = p_valid_q && (rd_data_i > CNT_W'(1));
    out_free = !out_valid_q || !out_stall_i;
    advance  = 1'b0;
    rd_en_o  = 1'b0;
    load_dup = 1'b0;
    load_tot = 1'b0;
    clear    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
      end
      ST_SCAN: begin
        // hold the pending bin while a duplicate cannot be placed
        advance  = !(cand && !out_free);
        rd_en_o  = advance && !iss_done_q;
        load_dup = cand && out_free;
      end
      ST_TOTAL: begin
        load_tot = out_free;
        clear    = out_free;
      end
      default: begin
      end
    endcase
  end

  assign rd_addr_o   = idx_q;
  assign sts_o.busy  = (state_q != ST_IDLE);
  assign sts_o.clear = clear;

  // Scan counters and pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      iss_done_q <= 1'b0;
      p_valid_q  <= 1'b0;
      dups_q     <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_IDLE) && start_i) begin
        idx_q      <= '0;
        iss_done_q <= 1'b0;
        p_valid_q  <= 1'b0;
        dups_q     <= '0;
      end else if (advance) begin
        p_valid_q <= rd_en_o;
        if (rd_en_o) begin
          idx_q <= idx_q + BIN_W'(1);
          if (idx_q == largest_i) iss_done_q <= 1'b1;
        end
        if (load_dup) dups_q <= dups_q + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p_idx_q <= idx_q;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_dup || load_tot) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_dup) begin
      out_q.dup_value   <= VAL_W'(p_idx_q);
      out_q.occurrences <= OCC_W'(rd_data_i);
      out_q.total_flag  <= 1'b0;
      out_q.last_result <= 1'b0;
    end else if (load_tot) begin
      out_q.dup_value   <= '0;
      out_q.occurrences <= dups_q;
      out_q.total_flag  <= 1'b1;
      out_q.last_result <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/histogram_duplicate_reporter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_duplicate_reporter_core
// Counts values into a histogram memory; on the last item, reports every
// value seen more than once and a closing total, then clears for the next set.
//
//   channel | direction | payload  | handshake
//   --------+-----------+----------+----------------------------
//   in      | input     | hdr_in_t | in_valid_i / in_stall_o
//   out     | output    | hdr_out_t| out_valid_o / out_stall_i
//
// Loading takes one item per cycle: read-modify-write on the bin memory,
// with a forwarding register covering back-to-back hits on the same bin.
// After the last item, input stalls for the report scan up to the largest value
// (one bin read per cycle from the single read port) plus any output stalls.
// Reset clears the per-bin valid bits at once; no clearing pass is needed.
// An output stall holds the scan on a pending duplicate bin; nothing is dropped.
// ----------------------------------------------------------------------------
module histogram_duplicate_reporter_core
  import hdr_pkg::*;
#(
  parameter int unsigned NUM_BINS  = 32,
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  hdr_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output hdr_out_t out_data_o
);

  localparam int unsigned BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

  hdr_sts_t         sts;
  logic             in_accept;
  logic             in_range;
  logic [BIN_W-1:0] in_addr;
  logic [BIN_W-1:0] largest_q;

  logic             s1_valid_q;
  logic             s1_inc_q;
  logic             s1_last_q;
  logic [BIN_W-1:0] s1_addr_q;

  logic             fwd_hit_q;
  logic [CNT_W-1:0] fwd_data_q;

  logic             ld_rd_en;
  logic             scan_rd_en;
  logic [BIN_W-1:0] scan_rd_addr;
  logic             mem_rd_en;
  logic [BIN_W-1:0] mem_rd_addr;
  logic [CNT_W-1:0] mem_rd_data;
  logic             wr_en;
  logic [CNT_W-1:0] cnt_old;
  logic [CNT_W-1:0] cnt_new;

  // Input transfer and bin lookup
  assign in_stall_o = sts.busy || (s1_valid_q && s1_last_q);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_range   = (32'(in_data_i.item_value) < 32'(NUM_BINS));
  assign in_addr    = BIN_W'(in_data_i.item_value);
  assign ld_rd_en   = in_accept && in_range;

  // Update stage: saturating increment with forwarding
  assign wr_en   = s1_valid_q && s1_inc_q;
  assign cnt_old = fwd_hit_q ? fwd_data_q : mem_rd_data;
  assign cnt_new = (cnt_old < CNT_W'(MAX_ITEMS)) ? cnt_old + CNT_W'(1) : cnt_old;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
      largest_q  <= '0;
    end else begin
      s1_valid_q <= in_accept;
      fwd_hit_q  <= wr_en && ld_rd_en && (in_addr == s1_addr_q);
      if (sts.clear) begin
        largest_q <= '0;
      end else if (ld_rd_en && (in_addr > largest_q)) begin
        largest_q <= in_addr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_inc_q  <= in_range;
      s1_last_q <= in_data_i.last_item;
      s1_addr_q <= in_addr;
    end
    fwd_data_q <= cnt_new;
  end

  // Read port shared between loading and the report scan
  assign mem_rd_en   = sts.busy ? scan_rd_en : ld_rd_en;
  assign mem_rd_addr = sts.busy ? scan_rd_addr : in_addr;

  hdr_bin_mem #(
    .DEPTH (NUM_BINS),
    .AW    (BIN_W),
    .DW    (CNT_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (cnt_new),
    .clr_i     (sts.clear)
  );

  hdr_scan #(
    .BIN_W (BIN_W),
    .CNT_W (CNT_W)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s1_valid_q && s1_last_q),
    .largest_i   (largest_q),
    .rd_en_o     (scan_rd_en),
    .rd_addr_o   (scan_rd_addr),
    .rd_data_i   (mem_rd_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .sts_o       (sts)
  );

`ifndef SYNTHESIS
  // No bin write may land while the report scan owns the memory
  a_no_wr_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.busy |-> !wr_en)
    else $error("bin write during report scan");

  // A committed last item always starts the report
  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q) |=> sts.busy)
    else $error("report did not start after last item");

  // Largest value stays a legal bin index
  a_largest_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(largest_q) < 32'(NUM_BINS))
    else $error("largest value outside bins");

  // Clearing leaves the maximum at zero
  a_clear_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.clear |=> (largest_q == '0))
    else $error("maximum not cleared after report");
`endif

endmodule
